// ===== rtl/core/dnv_pkg.sv =====
// Package for the dataset name validator: payload words, name state and register types.
// Used by dnv_step and dataset_name_validator; depends on nothing else.
package dnv_pkg;

  // Width of the saturating total length counter (6 to 8).
  localparam int LENGTH_BITS = 6;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 6;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_QUALIFIER_LEN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MEMBER_LEN    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEVELS        = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_NAME_LEN      = 2'd3;

  // Reset values of the limits.
  localparam logic [3:0] RST_MAX_QUALIFIER_LEN = 4'd8;
  localparam logic [3:0] RST_MAX_MEMBER_LEN    = 4'd8;
  localparam logic [4:0] RST_MAX_LEVELS        = 5'd22;
  localparam logic [5:0] RST_MAX_NAME_LEN      = 6'd44;

  // Result classes.
  localparam logic [1:0] CLASS_INVALID = 2'd0;
  localparam logic [1:0] CLASS_SINGLE  = 2'd1;
  localparam logic [1:0] CLASS_DATASET = 2'd2;
  localparam logic [1:0] CLASS_MEMBER  = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_word_t;

  typedef struct packed {
    logic [1:0] name_class;
    logic [4:0] level_total;
    logic [5:0] name_length;
  } result_word_t;

  typedef struct packed {
    logic [3:0] max_qualifier_len;
    logic [3:0] max_member_len;
    logic [4:0] max_levels;
    logic [5:0] max_name_len;
  } limits_t;

  typedef struct packed {
    logic [3:0]             level_length;
    logic [3:0]             member_length;
    logic [4:0]             levels_seen;
    logic [LENGTH_BITS-1:0] total_length;
    logic                   inside_member;
    logic                   member_done;
    logic                   previous_was_dot;
    logic                   name_bad;
    logic                   saw_dot;
    logic                   after_close;
  } name_state_t;

endpackage

// ===== rtl/core/dnv_step.sv =====
// Per-character update of the name state and the final classification.
// Depends on dnv_pkg.
module dnv_step import dnv_pkg::*; (
  input  name_state_t  state,
  input  limits_t      limits,
  input  char_word_t   char_word,
  output name_state_t  state_next,
  output result_word_t result_word
);

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_DOLR  = 8'h24;
  localparam logic [LENGTH_BITS-1:0] TOTAL_MAX = '1;
  localparam int CMP_W = LENGTH_BITS + 2;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) ||
           (c == CHAR_AT) || (c == CHAR_HASH) || (c == CHAR_DOLR);
  endfunction

  name_state_t      upd;
  logic [7:0]       c;
  logic [CMP_W-1:0] limit;
  logic             bad;

  always_comb begin
    c   = char_word.char_code;
    upd = state;
    upd.previous_was_dot = 1'b0;
    upd.after_close      = 1'b0;

    if (state.total_length >= TOTAL_MAX) begin
      upd.name_bad = 1'b1;
    end else begin
      upd.total_length = state.total_length + 1'b1;
    end

    if (state.after_close && (c != CHAR_DOT)) begin
      // Only a dot may follow a closed member.
      upd.name_bad = 1'b1;
    end else if (c == CHAR_DOT) begin
      if (state.inside_member || state.previous_was_dot) upd.name_bad = 1'b1;
      upd.saw_dot          = 1'b1;
      upd.previous_was_dot = 1'b1;
      upd.level_length     = '0;
    end else if (c == CHAR_OPEN) begin
      if (state.inside_member || state.member_done || (state.level_length == '0)) begin
        upd.name_bad = 1'b1;
      end
      upd.inside_member = 1'b1;
      upd.member_length = '0;
    end else if (c == CHAR_CLOSE) begin
      if (!state.inside_member || (state.member_length == '0)) upd.name_bad = 1'b1;
      upd.inside_member = 1'b0;
      upd.member_done   = 1'b1;
      upd.after_close   = 1'b1;
    end else if (is_name_char(c)) begin
      if (state.inside_member) begin
        if (state.member_length >= limits.max_member_len) begin
          upd.name_bad = 1'b1;
        end else begin
          upd.member_length = state.member_length + 1'b1;
        end
      end else begin
        if (state.level_length == '0) begin
          if (is_digit(c)) upd.name_bad = 1'b1;
          if (state.levels_seen != 5'd31) begin
            upd.levels_seen = state.levels_seen + 1'b1;
          end else begin
            upd.name_bad = 1'b1;
          end
          if (upd.levels_seen > limits.max_levels) upd.name_bad = 1'b1;
        end
        if (state.level_length >= limits.max_qualifier_len) begin
          upd.name_bad = 1'b1;
        end else begin
          upd.level_length = state.level_length + 1'b1;
        end
      end
    end else begin
      upd.name_bad = 1'b1;
    end

    // Final checks, applied on the updated state.
    limit = CMP_W'(limits.max_name_len);
    if (upd.member_done) begin
      limit = limit + CMP_W'(limits.max_member_len) + CMP_W'(2);
    end
    bad = upd.name_bad || upd.inside_member || (upd.levels_seen == '0) ||
          (CMP_W'(upd.total_length) > limit);

    if (bad) begin
      result_word.name_class = CLASS_INVALID;
    end else if (upd.member_done) begin
      result_word.name_class = CLASS_MEMBER;
    end else if ((upd.levels_seen == 5'd1) && !upd.saw_dot) begin
      result_word.name_class = CLASS_SINGLE;
    end else begin
      result_word.name_class = CLASS_DATASET;
    end
    result_word.level_total = upd.levels_seen;
    result_word.name_length = (CMP_W'(upd.total_length) > CMP_W'(63)) ? 6'd63 :
                              upd.total_length[5:0];

    // The last character ends the name and the state starts over.
    state_next = char_word.last_char ? '0 : upd;
  end

endmodule

// ===== rtl/core/dataset_name_validator.sv =====
// Top level of the dataset name validator: input stage, name state, result register.
// Depends on dnv_pkg and dnv_step.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   char     | char_valid / char_ready    | char_word (char_code, last_char)
//   result   | result_valid / result_ready| result_word (name_class, level_total,
//            |                            |   name_length)
//   cfg      | cfg_we                     | cfg_index, cfg_data
//
// One character is taken every cycle unless the input stalls. A character waits in
// the input stage, where the step logic updates the name state; on the last
// character the class is written into the result register, so a result passes
// through the input stage and then the result register. Only the result register
// can stall the input: a last character waits in the input stage while an earlier
// result is not taken. Reset (synchronous, active high) clears the name state,
// empties both stages and loads the default limits.
module dataset_name_validator import dnv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   char_valid,
  output logic                   char_ready,
  input  char_word_t             char_word,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_word_t           result_word,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configured limits.
  limits_t limits;

  // Input stage holding the character being worked on.
  logic       stage_valid;
  char_word_t stage_word;

  // State of the name in progress.
  name_state_t  state;
  name_state_t  state_next;
  result_word_t result_next;

  logic advance;

  // The stage moves on unless it holds a last character and the result register
  // still holds a result that has not been taken.
  assign advance    = stage_valid &&
                      (!stage_word.last_char || !result_valid || result_ready);
  assign char_ready = !stage_valid || advance;

  dnv_step u_step (
    .state       (state),
    .limits      (limits),
    .char_word   (stage_word),
    .state_next  (state_next),
    .result_word (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_qualifier_len <= RST_MAX_QUALIFIER_LEN;
      limits.max_member_len    <= RST_MAX_MEMBER_LEN;
      limits.max_levels        <= RST_MAX_LEVELS;
      limits.max_name_len      <= RST_MAX_NAME_LEN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_QUALIFIER_LEN: limits.max_qualifier_len <= cfg_data[3:0];
        REG_MAX_MEMBER_LEN:    limits.max_member_len    <= cfg_data[3:0];
        REG_MAX_LEVELS:        limits.max_levels        <= cfg_data[4:0];
        REG_MAX_NAME_LEN:      limits.max_name_len      <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (char_ready) begin
      stage_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      stage_word <= char_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && stage_word.last_char) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_word.last_char) begin
      result_word <= result_next;
    end
  end

`ifndef SYNTHESIS
  // The name state starts over after every last character.
  assert property (@(posedge clk) disable iff (rst)
    advance && stage_word.last_char |=>
      (state.total_length == '0) && (state.levels_seen == '0) && !state.name_bad)
    else $error("name state not cleared after last character");

  // A valid name has at least one level.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_word.name_class != CLASS_INVALID) |->
      (result_word.level_total != '0))
    else $error("valid class with no level");

  // A single qualifier is exactly one level.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_word.name_class == CLASS_SINGLE) |->
      (result_word.level_total == 5'd1))
    else $error("single qualifier with level count other than one");

  // A last character blocked by a pending result stays in the input stage.
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && stage_word.last_char && result_valid && !result_ready |=>
      stage_valid && stage_word.last_char)
    else $error("blocked last character lost");
`endif

endmodule

// ===== bench/dataset_name_validator_tb.sv =====
// Self-checking testbench for dataset_name_validator: streams names one character word
// at a time and compares every result word with a built-in predictor of the validator.
// Depends on dnv_pkg and the dataset_name_validator RTL.
module dataset_name_validator_tb;
  import dnv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Character codes that carry meaning in a dataset name.
  localparam logic [7:0] CH_DOT     = ".";
  localparam logic [7:0] CH_OPEN    = "(";
  localparam logic [7:0] CH_CLOSE   = ")";
  localparam logic [7:0] CH_AT      = "@";
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_DOLLAR  = "$";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_UPPER_Z = "Z";
  localparam logic [7:0] CH_LOWER_Z = "z";
  localparam logic [7:0] CH_NUL     = 8'h00;

  // The length counter saturates at all ones; the reported length saturates at 63.
  localparam logic [LENGTH_BITS-1:0] COUNT_FULL = '1;
  localparam int                     REPORTED_LENGTH_MAX = 63;
  localparam logic [4:0]             LEVELS_FULL = 5'd31;

  // Cycles the block may still need after its last result before a register write
  // is safe, and the length of the long receiver hold-off.
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 300;

  // Tracks the validator's name state and keeps the verdicts that are still owed.
  class name_scoreboard;
    logic [3:0]             lim_qual;
    logic [3:0]             lim_member;
    logic [4:0]             lim_levels;
    logic [5:0]             lim_name;
    logic [3:0]             level_len;
    logic [3:0]             member_len;
    logic [4:0]             levels;
    logic [LENGTH_BITS-1:0] char_count;
    bit                     in_member;
    bit                     member_closed;
    bit                     last_dot;
    bit                     last_close;
    bit                     bad;
    bit                     had_dot;
    result_word_t           pending_verdicts[$];
    int                     mismatches;
    int                     names_checked;
    int                     class_seen[4];

    function new();
      lim_qual   = RST_MAX_QUALIFIER_LEN;
      lim_member = RST_MAX_MEMBER_LEN;
      lim_levels = RST_MAX_LEVELS;
      lim_name   = RST_MAX_NAME_LEN;
      mismatches = 0;
      names_checked = 0;
      foreach (class_seen[i]) class_seen[i] = 0;
      clear_name();
    endfunction

    function void clear_name();
      level_len     = '0;
      member_len    = '0;
      levels        = '0;
      char_count    = '0;
      in_member     = 1'b0;
      member_closed = 1'b0;
      last_dot      = 1'b0;
      last_close    = 1'b0;
      bad           = 1'b0;
      had_dot       = 1'b0;
    endfunction

    function void set_limit(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAX_QUALIFIER_LEN: lim_qual   = data[3:0];
        REG_MAX_MEMBER_LEN:    lim_member = data[3:0];
        REG_MAX_LEVELS:        lim_levels = data[4:0];
        REG_MAX_NAME_LEN:      lim_name   = data[5:0];
        default: ;
      endcase
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_name_char(logic [7:0] c);
      return is_digit(c) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
             c == CH_AT || c == CH_HASH || c == CH_DOLLAR;
    endfunction

    function void advance_name(logic [7:0] c);
      bit was_dot;
      bit was_close;
      was_dot    = last_dot;
      was_close  = last_close;
      last_dot   = 1'b0;
      last_close = 1'b0;
      if (char_count == COUNT_FULL) bad = 1'b1;
      else char_count++;
      if (was_close && c != CH_DOT) begin
        bad = 1'b1;
        return;
      end
      if (c == CH_DOT) begin
        if (in_member || was_dot) bad = 1'b1;
        had_dot   = 1'b1;
        last_dot  = 1'b1;
        level_len = '0;
      end else if (c == CH_OPEN) begin
        if (in_member || member_closed || level_len == 0) bad = 1'b1;
        in_member  = 1'b1;
        member_len = '0;
      end else if (c == CH_CLOSE) begin
        if (!in_member || member_len == 0) bad = 1'b1;
        in_member     = 1'b0;
        member_closed = 1'b1;
        last_close    = 1'b1;
      end else if (is_name_char(c)) begin
        if (in_member) begin
          if (member_len >= lim_member) bad = 1'b1;
          else member_len++;
        end else begin
          if (level_len == 0) begin
            if (is_digit(c)) bad = 1'b1;
            if (levels != LEVELS_FULL) levels++;
            else bad = 1'b1;
            if (levels > lim_levels) bad = 1'b1;
          end
          if (level_len >= lim_qual) bad = 1'b1;
          else level_len++;
        end
      end else begin
        bad = 1'b1;
      end
    endfunction

    function result_word_t close_name();
      result_word_t verdict;
      bit           fail;
      int           limit;
      fail  = bad || in_member || levels == 0;
      limit = int'(lim_name);
      if (member_closed) limit += int'(lim_member) + 2;
      if (int'(char_count) > limit) fail = 1'b1;
      if (fail) verdict.name_class = CLASS_INVALID;
      else if (member_closed) verdict.name_class = CLASS_MEMBER;
      else if (levels == 1 && !had_dot) verdict.name_class = CLASS_SINGLE;
      else verdict.name_class = CLASS_DATASET;
      verdict.level_total = levels;
      verdict.name_length = (int'(char_count) > REPORTED_LENGTH_MAX) ?
                            6'(REPORTED_LENGTH_MAX) : 6'(char_count);
      clear_name();
      return verdict;
    endfunction

    // Called for every character word the block accepts.
    function void note_char(char_word_t w);
      advance_name(w.char_code);
      if (w.last_char) pending_verdicts.push_back(close_name());
    endfunction

    // Called for every result word the block hands over.
    function void check_result(result_word_t got);
      result_word_t want;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word with no name pending: class %0d levels %0d length %0d",
                   $realtime, got.name_class, got.level_total, got.name_length);
        return;
      end
      want = pending_verdicts.pop_front();
      names_checked++;
      class_seen[want.name_class]++;
      if (got.name_class !== want.name_class || got.level_total !== want.level_total ||
          got.name_length !== want.name_length) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: name %0d: expected class %0d levels %0d length %0d, got %0d %0d %0d",
                   $realtime, names_checked, want.name_class, want.level_total,
                   want.name_length, got.name_class, got.level_total, got.name_length);
      end
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   char_valid = 1'b0;
  logic                   char_ready;
  char_word_t             char_word = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_word_t           result_word;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  name_scoreboard sb = new();

  // Characters of the name about to be sent.
  logic [7:0] name_buf[$];
  // When set, neither side inserts idle cycles.
  bit         calm = 1'b0;
  // A request from the stimulus for the receiver to hold off for this many cycles.
  int         hold_cycles = 0;
  int         chars_sent = 0;
  int         settings_used = 1;

  dataset_name_validator i_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Handshakes are sampled at the rising edge, before any of this edge's updates land,
  // so the monitor sees exactly what the block saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && char_ready) sb.note_char(char_word);
      if (result_valid && result_ready) sb.check_result(result_word);
    end
  end

  // Offers one character word after an idle gap and holds it until the block takes it.
  // Entered and left right after a rising edge.
  task automatic send_char(input char_word_t w, input int gap);
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_word  <= w;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
  endtask

  // Sends the buffered name; only its final character carries the last flag.
  task automatic send_name();
    char_word_t w;
    for (int i = 0; i < name_buf.size(); i++) begin
      w.char_code = name_buf[i];
      w.last_char = (i == name_buf.size() - 1);
      send_char(w, calm ? 0 : $urandom_range(0, 9));
      chars_sent++;
    end
  endtask

  task automatic send_text(input string s);
    name_buf.delete();
    for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    send_name();
  endtask

  // Drops valid and waits until every owed verdict has arrived, then lets the block
  // settle for the given number of cycles. Always waits for a clock edge, so the
  // next drive of char_valid falls in a later time step.
  task automatic drain(input int settle);
    char_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_verdicts.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Register writes happen only while the block is idle; the predictor follows along.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_limit(idx, data);
    @(posedge clk);
  endtask

  task automatic write_limits(input logic [CFG_DATA_W-1:0] q, m, l, n);
    write_reg(REG_MAX_QUALIFIER_LEN, q);
    write_reg(REG_MAX_MEMBER_LEN, m);
    write_reg(REG_MAX_LEVELS, l);
    write_reg(REG_MAX_NAME_LEN, n);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // A random character that is legal in a level; a leading one is never a digit.
  function automatic logic [7:0] pick_char(input bit leading);
    int r;
    r = $urandom_range(0, leading ? 54 : 64);
    if (r < 26) return CH_UPPER_A + 8'(r);
    if (r < 52) return CH_LOWER_A + 8'(r - 26);
    if (r == 52) return CH_AT;
    if (r == 53) return CH_HASH;
    if (r == 54) return CH_DOLLAR;
    return CH_ZERO + 8'(r - 55);
  endfunction

  // Builds one name into name_buf. Most names are well formed for the current limits,
  // with lengths and counts that sometimes step one past a limit; some get a single
  // corrupted character, some are pure noise, and a few run past the length counter.
  task automatic build_name();
    int      shape;
    int      qmax;
    int      mmax;
    int      lmax;
    int      nlev;
    int      len;
    int      pos;
    int      goal;
    logic [7:0] stray;
    name_buf.delete();
    qmax  = (sb.lim_qual == 0) ? 1 : sb.lim_qual;
    mmax  = (sb.lim_member == 0) ? 1 : sb.lim_member;
    lmax  = (sb.lim_levels == 0) ? 1 : sb.lim_levels;
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      // Noise: any byte at all.
      len = $urandom_range(1, 6);
      repeat (len) name_buf.push_back(8'($urandom_range(0, 255)));
    end else if (shape == 2) begin
      // Long names push the length counter into saturation.
      goal = 58 + $urandom_range(0, 14);
      while (name_buf.size() < goal) begin
        if (name_buf.size() > 0) name_buf.push_back(CH_DOT);
        name_buf.push_back(pick_char(1'b1));
        for (int k = 1; k < qmax; k++) name_buf.push_back(pick_char(1'b0));
      end
    end else begin
      nlev = ($urandom_range(0, 7) == 0) ? $urandom_range(1, lmax + 1) :
                                           $urandom_range(1, (lmax < 4) ? lmax : 4);
      if ($urandom_range(0, 9) == 0) name_buf.push_back(CH_DOT);
      for (int l = 0; l < nlev; l++) begin
        if (l > 0) name_buf.push_back(CH_DOT);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, qmax + 1) :
                                            $urandom_range(1, qmax);
        for (int k = 0; k < len; k++) name_buf.push_back(pick_char(k == 0));
      end
      if ($urandom_range(0, 2) == 0) begin
        name_buf.push_back(CH_OPEN);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, mmax + 1) :
                                            $urandom_range(1, mmax);
        repeat (len) name_buf.push_back(pick_char(1'b0));
        name_buf.push_back(CH_CLOSE);
      end
      if ($urandom_range(0, 9) == 0) name_buf.push_back(CH_DOT);
      if (shape >= 17) begin
        // Break the sequence at one place.
        pos = $urandom_range(0, name_buf.size() - 1);
        case ($urandom_range(0, 3))
          0: name_buf[pos] = 8'($urandom_range(0, 255));
          1: name_buf.delete(pos);
          default: begin
            case ($urandom_range(0, 3))
              0: stray = CH_DOT;
              1: stray = CH_OPEN;
              2: stray = CH_CLOSE;
              default: stray = CH_ZERO + 8'($urandom_range(0, 9));
            endcase
            name_buf.insert(pos, stray);
          end
        endcase
        if (name_buf.size() == 0) name_buf.push_back(CH_DOT);
      end
    end
  endtask

  // The receiver draws a stall before every result word and honors long hold-off
  // requests, counting the cycles itself while the sender keeps offering words.
  initial begin : result_sink
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      stall += hold_cycles;
      hold_cycles = 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid && hold_cycles == 0) @(posedge clk);
    end
  end

  initial begin : stimulus
    int phase_chars;
    bit paused;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed names at the reset limits: each class, both tolerated dots, and the
    // ways a level or a member can be malformed.
    calm = 1'b0;
    send_text("A");
    send_text(".A");
    send_text("A.");
    send_text("A..B");
    send_text(".");
    send_text("ABCDEFGHI");
    send_text("1A");
    send_text("A(B)");
    send_text("A.B(1)");
    send_text("A()");
    send_text("A(B.C)");
    send_text("A)");
    send_text("A(B");
    send_text("A(B)C");
    send_text("(A)");
    send_text("A.(B)");
    send_text("A(B(C))");
    send_text("A(B)(C)");
    send_text("A(123456789)");
    send_text("@#$");
    send_text("A B");
    name_buf.delete();
    name_buf.push_back(CH_NUL);
    send_name();
    drain(SETTLE_CYCLES);

    // Random names under a series of limit settings: smallest legal, largest, all zero,
    // raw six-bit values that exercise the register masking, and the reset values
    // again with no idling on either side.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: write_limits(6'd1, 6'd1, 6'd1, 6'd1);
        1: write_limits(6'd15, 6'd15, 6'd31, 6'd63);
        2: write_limits(6'd0, 6'd0, 6'd0, 6'd0);
        6: write_limits(RST_MAX_QUALIFIER_LEN, RST_MAX_MEMBER_LEN, RST_MAX_LEVELS,
                        RST_MAX_NAME_LEN);
        default: write_limits(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
      endcase
      // Under the widest limits the receiver stops for a long stretch, so a finished
      // name waits in the block and the input stalls behind it.
      if (ph == 1) hold_cycles = HOLD_OFF_CYCLES;
      phase_chars = 0;
      paused = 1'b0;
      while (phase_chars < 80) begin
        calm = (ph == 6) || ($urandom_range(0, 7) == 0);
        build_name();
        send_name();
        phase_chars += name_buf.size();
        // Once per phase the sender waits for the block to empty completely.
        if (!paused && phase_chars >= 40) begin
          drain(0);
          paused = 1'b1;
        end
      end
      drain(SETTLE_CYCLES);
    end

    $display("Sent %0d characters under %0d limit settings; %0d names checked.",
             chars_sent, settings_used, sb.names_checked);
    $display("Verdicts: %0d invalid, %0d single, %0d dataset, %0d with member.",
             sb.class_seen[CLASS_INVALID], sb.class_seen[CLASS_SINGLE],
             sb.class_seen[CLASS_DATASET], sb.class_seen[CLASS_MEMBER]);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("** dataset_name_validator: PASSED **");
    end else begin
      $display("%0d mismatches, %0d verdicts still owed.", sb.mismatches,
               sb.pending_verdicts.size());
      $display("** dataset_name_validator: FAILED **");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout with %0d verdicts still owed.", sb.pending_verdicts.size());
    $display("** dataset_name_validator: FAILED **");
    $finish;
  end

endmodule

// ===== dataset_name_validator.f =====
rtl/core/dnv_pkg.sv
rtl/core/dnv_step.sv
rtl/core/dataset_name_validator.sv
bench/dataset_name_validator_tb.sv
